>>> src/mri_pkg.sv
// Package with constants, register indexes and types for the mixed-radix index unravel block.
`default_nettype none

package mri_pkg;

    localparam int MAX_DIMS   = 6;
    localparam int INDEX_BITS = 48;
    localparam int SIZE_BITS  = 32;
    localparam int AXIS_BITS  = 3;
    localparam int CNT_BITS   = $clog2(INDEX_BITS);

    // Configuration register indexes.
    localparam logic [AXIS_BITS-1:0] CFG_NUM_DIMS   = 3'd0;
    localparam logic [AXIS_BITS-1:0] CFG_DIM_SIZE_0 = 3'd1;
    localparam logic [AXIS_BITS-1:0] CFG_DIM_SIZE_5 = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

`default_nettype wire

>>> src/mixed_radix_index_unravel.sv
// Top level: splits a flat index into row-major axis coordinates with a bit-serial divider.
// Each axis of an item runs through the restoring divider in S_DIV (one quotient bit a cycle),
// then S_EMIT hands the remainder to the output register, waiting while the output stalls.
// A new flat index is taken only in S_IDLE, once the last axis of the item has been handed
// on; an item with no axes is taken and dropped without leaving S_IDLE.
// Synchronous active-low reset: idle, no axes configured, all axis sizes one.
`default_nettype none

module mixed_radix_index_unravel import mri_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [AXIS_BITS-1:0]  i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]  i_cfg_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [INDEX_BITS-1:0] s_axis_tdata,   // [47:0] flat_index
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [SIZE_BITS-1:0]       m_axis_tdata,   // [31:0] coordinate
    output logic [AXIS_BITS-1:0]       m_axis_tuser,   // [2:0] axis
    output logic                       m_axis_tlast
);

    logic [AXIS_BITS-1:0]  r_num_dims;
    logic [SIZE_BITS-1:0]  r_dim_size [MAX_DIMS];

    t_state                r_state;
    logic [INDEX_BITS-1:0] r_quot;
    logic [SIZE_BITS-1:0]  r_rem;
    logic [SIZE_BITS-1:0]  r_div;
    logic [AXIS_BITS-1:0]  r_axis;
    logic [CNT_BITS-1:0]   r_bit_cnt;

    logic                  r_out_valid;
    logic [SIZE_BITS-1:0]  r_out_coord;
    logic [AXIS_BITS-1:0]  r_out_axis;
    logic                  r_out_last;

    logic [AXIS_BITS-1:0]  w_dims_used;
    logic [SIZE_BITS:0]    w_shifted;
    logic                  w_ge;
    logic [SIZE_BITS:0]    w_diff;
    logic                  w_out_free;
    logic                  w_emit;
    logic [AXIS_BITS-1:0]  w_sel_axis;
    logic [SIZE_BITS-1:0]  w_sel_size;
    logic                  w_in_xfer;

    // Axis counts above the number of size registers saturate.
    assign w_dims_used = (r_num_dims > AXIS_BITS'(MAX_DIMS)) ? AXIS_BITS'(MAX_DIMS)
                                                              : r_num_dims;

    assign w_shifted = {r_rem, r_quot[INDEX_BITS-1]};
    assign w_diff    = w_shifted - {1'b0, r_div};
    assign w_ge      = (w_shifted >= {1'b0, r_div});

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_emit        = (r_state == S_EMIT) && w_out_free;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;

    // Axis whose size is loaded next: the last axis on a new item, else one further out.
    assign w_sel_axis = (r_state == S_IDLE) ? w_dims_used - AXIS_BITS'(1)
                                            : r_axis - AXIS_BITS'(1);
    // A size of zero is treated as one.
    assign w_sel_size = (r_dim_size[w_sel_axis] == '0) ? SIZE_BITS'(1)
                                                       : r_dim_size[w_sel_axis];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= '0;
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_dim_size[k] <= SIZE_BITS'(1);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_NUM_DIMS) begin
                r_num_dims <= i_cfg_data[AXIS_BITS-1:0];
            end else if (i_cfg_index >= CFG_DIM_SIZE_0 && i_cfg_index <= CFG_DIM_SIZE_5) begin
                r_dim_size[i_cfg_index - CFG_DIM_SIZE_0] <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_bit_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_xfer && w_dims_used != '0) begin
                        r_state   <= S_DIV;
                        r_axis    <= w_sel_axis;
                        r_bit_cnt <= '0;
                    end
                end
                S_DIV: begin
                    r_bit_cnt <= r_bit_cnt + CNT_BITS'(1);
                    if (r_bit_cnt == CNT_BITS'(INDEX_BITS - 1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (r_axis == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state   <= S_DIV;
                            r_axis    <= w_sel_axis;
                            r_bit_cnt <= '0;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath: the quotient register shifts left as the dividend bits move into the
    // remainder, and the new quotient bits fill in from the bottom.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_quot <= s_axis_tdata;
                    r_rem  <= '0;
                    r_div  <= w_sel_size;
                end
            end
            S_DIV: begin
                r_quot <= {r_quot[INDEX_BITS-2:0], w_ge};
                r_rem  <= w_ge ? w_diff[SIZE_BITS-1:0] : w_shifted[SIZE_BITS-1:0];
            end
            S_EMIT: begin
                if (w_out_free) begin
                    r_out_coord <= r_rem;
                    r_out_axis  <= r_axis;
                    r_out_last  <= (r_axis == '0);
                    r_rem       <= '0;
                    r_div       <= w_sel_size;
                end
            end
            default: begin
                r_rem <= '0;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_coord;
    assign m_axis_tuser  = r_out_axis;
    assign m_axis_tlast  = r_out_last;

    // The partial remainder never reaches the divisor while dividing.
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_bit_cnt == CNT_BITS'(INDEX_BITS - 1)) |=> (r_state == S_EMIT))
        else $error("division did not end after all quotient bits");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_axis < AXIS_BITS'(MAX_DIMS)))
        else $error("axis out of range while busy");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_out_free && r_axis == '0)
        |=> (r_state == S_IDLE && r_out_valid && r_out_last))
        else $error("axis 0 result did not end the item");

    a_no_result_zero_dims: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && w_dims_used == '0) |=> (r_state == S_IDLE))
        else $error("item with no axes left idle");

endmodule

`default_nettype wire

>>> test/tb_mixed_radix_index_unravel.sv
// Self-checking testbench for the mixed-radix index unravel block, driven through its streams.
`timescale 1ns / 1ps

module tb_mixed_radix_index_unravel import mri_pkg::*; ();

    localparam int ITEM_CYCLES  = MAX_DIMS * (INDEX_BITS + 1) + 1;
    localparam int TAIL_CYCLES  = 2 * ITEM_CYCLES;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 330;

    localparam logic [AXIS_BITS-1:0] CFG_UNUSED = CFG_DIM_SIZE_5 + 1'b1;

    typedef struct packed {
        logic [AXIS_BITS-1:0] axis;
        logic [SIZE_BITS-1:0] coordinate;
        logic                 last;
    } t_coord;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [AXIS_BITS-1:0]  i_cfg_index;
    logic [SIZE_BITS-1:0]  i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [INDEX_BITS-1:0] s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [SIZE_BITS-1:0]  m_axis_tdata;
    logic [AXIS_BITS-1:0]  m_axis_tuser;
    logic                  m_axis_tlast;

    // Shadow copy of the shape registers as the block should hold them.
    logic [2:0]            shape_dims;
    logic [SIZE_BITS-1:0]  axis_size [MAX_DIMS];
    logic [SIZE_BITS-1:0]  plan_size [MAX_DIMS];

    t_coord                coord_q [$];
    int                    err_count;
    int                    cycle_count;
    int                    ready_hold;
    bit                    no_idle;

    mixed_radix_index_unravel uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [47:0] flat_index
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [31:0] coordinate
        .m_axis_tuser  (m_axis_tuser),   // [2:0] axis
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int axes_used();
        return (shape_dims > MAX_DIMS) ? MAX_DIMS : int'(shape_dims);
    endfunction

    // Peel coordinates off from the last axis towards axis 0; any quotient
    // left after axis 0 is simply dropped.
    function automatic void predict_coords(input logic [INDEX_BITS-1:0] idx);
        logic [INDEX_BITS-1:0] quo;
        logic [SIZE_BITS-1:0]  d;
        t_coord                c;
        int                    a;
        quo = idx;
        for (a = axes_used() - 1; a >= 0; a--) begin
            d = (axis_size[a] == '0) ? 32'd1 : axis_size[a];
            c.axis       = AXIS_BITS'(a);
            c.coordinate = SIZE_BITS'(quo % d);
            c.last       = (a == 0);
            quo          = quo / d;
            coord_q      = {coord_q, c};
        end
    endfunction

    function automatic logic [INDEX_BITS-1:0] random_index();
        logic [63:0]     raw;
        longint unsigned span;
        logic [SIZE_BITS-1:0] d;
        bit              fits;
        int              a;
        raw  = {$urandom, $urandom};
        span = 1;
        fits = 1'b1;
        for (a = 0; a < axes_used(); a++) begin
            d = (axis_size[a] == '0) ? 32'd1 : axis_size[a];
            if (span > ((64'd1 << INDEX_BITS) / d)) fits = 1'b0;
            else span = span * d;
        end
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return INDEX_BITS'(raw[7:0]);
            3, 4: return raw[INDEX_BITS-1:0];
            default: return fits ? INDEX_BITS'(raw % span) : raw[INDEX_BITS-1:0];
        endcase
    endfunction

    task automatic write_reg(input logic [AXIS_BITS-1:0] index, input logic [SIZE_BITS-1:0] data,
                             input bit final_write);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (index == CFG_NUM_DIMS) shape_dims = data[2:0];
        else if (index <= CFG_DIM_SIZE_5) axis_size[index - CFG_DIM_SIZE_0] = data;
        if (final_write) begin
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic load_plan(input logic [SIZE_BITS-1:0] dims);
        int a;
        for (a = 0; a < MAX_DIMS; a++)
            write_reg(CFG_DIM_SIZE_0 + AXIS_BITS'(a), plan_size[a], 1'b0);
        write_reg(CFG_NUM_DIMS, dims, 1'b1);
    endtask

    // The valid line is only driven low when a gap is taken, so back-to-back
    // items never see a low and a high scheduled in the same step.
    task automatic send_index(input logic [INDEX_BITS-1:0] idx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= idx;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_coords(idx);
    endtask

    task automatic pause_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (coord_q.size() != 0) @(posedge i_clk);
    endtask

    // An item with no axes gives nothing back, so the queue cannot show when
    // it is done: wait out a tail once the queue is empty.
    task automatic settle();
        pause_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_index('0);
        send_index('1);
        settle();
        // Axis sizes left at their reset value of one give all-zero coordinates.
        write_reg(CFG_NUM_DIMS, 32'd6, 1'b1);
        send_index('1);
        settle();
    endtask

    task automatic test_extreme_values();
        plan_size = '{default: 32'hFFFF_FFFF};
        load_plan(32'd6);
        send_index('0);
        send_index('1);
        send_index(48'hFFFF_FFFF_FFFE);
        send_index(48'h0000_FFFF_FFFF);
        send_index(48'h8000_0000_0000);
        settle();
        plan_size = '{default: 32'd2};
        load_plan(32'd6);
        send_index(48'hAAAA_AAAA_AAAA);
        send_index(48'h5555_5555_5555);
        send_index('1);
        settle();
        plan_size = '{32'd7, 32'd1000, 32'd65536, 32'd1, 32'd1, 32'd1};
        load_plan(32'd3);
        send_index(48'd458_751_999);
        send_index(48'd123_456_789);
        settle();
        plan_size = '{default: 32'hFFFF_FFFF};
        load_plan(32'd1);
        send_index('1);
        send_index(48'h0000_FFFF_FFFE);
        settle();
    endtask

    task automatic test_special_cases();
        // A size written as zero behaves as a size of one.
        plan_size = '{32'd5, 32'd0, 32'd3, 32'd0, 32'd1, 32'd1};
        load_plan(32'd4);
        send_index(48'd14);
        send_index(48'h1234_5678_9ABC);
        settle();
        // An axis count of seven saturates to six.
        plan_size = '{32'd3, 32'd5, 32'd7, 32'd11, 32'd13, 32'd17};
        load_plan(32'd7);
        send_index(48'd255_254);
        send_index('1);
        settle();
        // Only the low three bits of the axis count register are kept.
        write_reg(CFG_NUM_DIMS, 32'hFFFF_FFFA, 1'b1);
        send_index(48'd1_000_000);
        settle();
        // A write to the unused register index must change nothing.
        write_reg(CFG_UNUSED, 32'd4, 1'b1);
        send_index(48'd1_000_001);
        settle();
    endtask

    task automatic test_random_shapes();
        int sent;
        int phase;
        int count;
        int k;
        int a;
        int dims;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            for (a = 0; a < MAX_DIMS; a++) begin
                case ($urandom_range(0, 5))
                    0: plan_size[a] = $urandom_range(1, 4);
                    1: plan_size[a] = $urandom_range(1, 16);
                    2: plan_size[a] = $urandom_range(1, 65535);
                    3: plan_size[a] = $urandom;
                    4: plan_size[a] = 32'hFFFF_FFFF;
                    default: plan_size[a] = 32'd1 << $urandom_range(0, 31);
                endcase
            end
            case ($urandom_range(0, 9))
                0: dims = 0;
                1: dims = 7;
                default: dims = $urandom_range(1, 6);
            endcase
            load_plan(SIZE_BITS'(dims));
            no_idle = (phase % 4 == 3);
            count = $urandom_range(30, 50);
            for (k = 0; k < count; k++) begin
                if (k == count / 2 || $urandom_range(0, 99) < 2) pause_for_results();
                send_index(random_index());
            end
            sent += count;
            settle();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    // Receiver: random back-pressure, with one assignment per clock edge.
    initial begin
        m_axis_tready <= 1'b0;
        ready_hold = 0;
        forever begin
            @(posedge i_clk);
            if (ready_hold > 0) begin
                ready_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 30) ready_hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : check_coords
        t_coord exp_c;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (coord_q.size() == 0) begin
                $error("coordinate transfer with none expected: axis %0d, coordinate %0d",
                       m_axis_tuser, m_axis_tdata);
                err_count++;
            end else begin
                exp_c = coord_q.pop_front();
                if (m_axis_tuser !== exp_c.axis) begin
                    $error("axis mismatch: expected %0d, actual %0d", exp_c.axis, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata !== exp_c.coordinate) begin
                    $error("coordinate mismatch: expected %0d, actual %0d",
                           exp_c.coordinate, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tlast !== exp_c.last) begin
                    $error("last mismatch: expected %0b, actual %0b", exp_c.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin
        err_count     = 0;
        no_idle       = 1'b0;
        shape_dims    = '0;
        axis_size     = '{default: 32'd1};
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_extreme_values();
        test_special_cases();
        test_random_shapes();
        settle();

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
src/mri_pkg.sv
src/mixed_radix_index_unravel.sv
test/tb_mixed_radix_index_unravel.sv
